### rtl/core/pm_sensor_frame_parser_assert.svh
// Assertion macros used by the frame parser checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PM_SENSOR_FRAME_PARSER_ASSERT_SVH
`define PM_SENSOR_FRAME_PARSER_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define PSFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define PSFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/psfp_pkg.sv
// Shared types and constants of the particle sensor frame parser.
// No dependencies; every other file of the block but the assertion header imports this package.
package psfp_pkg;

    localparam int TICK_W = 16;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int DATA_N = 4;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(5);

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hC0;
    localparam logic [BYTE_W-1:0] TAIL_BYTE  = 8'hAB;

    // Event codes carried in the op field.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Position inside the ten-byte frame.
    typedef enum logic [3:0] {
        POS_IDLE   = 4'd0,
        POS_HEADER = 4'd1,
        POS_D0     = 4'd2,
        POS_D1     = 4'd3,
        POS_D2     = 4'd4,
        POS_D3     = 4'd5,
        POS_D4     = 4'd6,
        POS_D5     = 4'd7,
        POS_SUM    = 4'd8,
        POS_TAIL   = 4'd9
    } psfp_pos_t;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] rx_byte;
    } psfp_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] pm25_raw;
        logic [WORD_W-1:0] pm10_raw;
    } psfp_result_t;

endpackage

### rtl/core/psfp_if.sv
// Valid/ready channel interfaces for the event input and the result output.
// Depends on psfp_pkg for field widths.
interface psfp_in_if;
    import psfp_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface psfp_out_if;
    import psfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pm25_raw;
    logic [WORD_W-1:0] pm10_raw;

    modport source (output valid, output pm25_raw, output pm10_raw, input ready);
    modport sink (input valid, input pm25_raw, input pm10_raw, output ready);
endinterface

### rtl/core/pm_sensor_frame_parser.sv
// Top level of the particle sensor frame parser.
// Depends on psfp_pkg, psfp_if, psfp_in_stage, psfp_parser and psfp_out_stage.
//
// The parser takes one event beat per cycle (a received byte or a timer tick)
// and emits one result beat, the PM2.5 and PM10 words, for every 10-byte frame
// AA C0 d0..d5 sum AB that passes its checksum. An event passes an input
// register and is then applied to the frame state, which loads the result
// register when a good tail byte is applied. Throughput is one event per cycle,
// set by the state update between the input and result registers; the input
// stalls only while a finished result waits and the event in hand would
// produce another. The user writes the timeout through cfg_wr_en and
// cfg_wr_data only while no event is in flight; the block does not enforce it.
module pm_sensor_frame_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [psfp_pkg::TICK_W-1:0] cfg_wr_data,
    psfp_in_if.sink                     evt,
    psfp_out_if.source                  res
);
    import psfp_pkg::*;

    logic         item_valid;
    psfp_item_t   item;
    logic         hit;
    logic         out_free;
    logic         take;
    psfp_result_t result;

    // The held event is applied unless its result has nowhere to go.
    assign take = item_valid && (!hit || out_free);

    psfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    psfp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (take),
        .item        (item),
        .hit         (hit),
        .result      (result)
    );

    psfp_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (take && hit),
        .data  (result),
        .free  (out_free),
        .res   (res)
    );

endmodule

### rtl/core/psfp_in_stage.sv
// Input register of the frame parser: holds one event beat for the parser.
// Depends on psfp_pkg and psfp_in_if.
module psfp_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    psfp_in_if.sink              evt,
    input  logic                 take,
    output logic                 item_valid,
    output psfp_pkg::psfp_item_t item
);
    import psfp_pkg::*;

    logic       valid_reg;
    psfp_item_t item_reg;
    logic       accept;

    // A new beat may enter when the register is empty or drains this cycle.
    assign evt.ready  = !valid_reg || take;
    assign accept     = evt.valid && evt.ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Event payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op      <= evt.op;
            item_reg.rx_byte <= evt.rx_byte;
        end
    end

endmodule

### rtl/core/psfp_parser.sv
// Frame state machine: position, running sum, data bytes and tick timeout.
// Depends on psfp_pkg.
module psfp_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [psfp_pkg::TICK_W-1:0]   cfg_wr_data,
    input  logic                          step,
    input  psfp_pkg::psfp_item_t          item,
    output logic                          hit,
    output psfp_pkg::psfp_result_t        result
);
    import psfp_pkg::*;

    psfp_pos_t         pos_reg, pos_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              armed_reg, armed_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic [TICK_W-1:0] timeout_reg;
    logic [BYTE_W-1:0] data_reg [DATA_N];
    logic              data_we;
    logic [1:0]        data_idx;
    logic [BYTE_W-1:0] b;

    assign b        = item.rx_byte;
    assign data_idx = 2'(pos_reg - POS_D0);

    // A tail byte 0xAB closes a good frame.
    assign hit = (pos_reg == POS_TAIL) && (item.op == OP_BYTE) && (b == TAIL_BYTE);

    assign result.pm25_raw = {data_reg[1], data_reg[0]};
    assign result.pm10_raw = {data_reg[3], data_reg[2]};

    // Timeout register; the user writes it only while the block is idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_IDLE;
            sum_reg   <= '0;
            armed_reg <= 1'b0;
            ticks_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            armed_reg <= armed_next;
            ticks_reg <= ticks_next;
        end
    end

    // Captured data bytes d0..d3.
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_reg[data_idx] <= b;
        end
    end

    // Next state for one event.
    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        armed_next = armed_reg;
        ticks_next = ticks_reg;
        data_we    = 1'b0;

        if (step)
        begin
            if (item.op == OP_TICK)
            begin
                // Count down only while a frame is in progress.
                if (armed_reg)
                begin
                    if (ticks_reg <= TICK_W'(1))
                    begin
                        ticks_next = '0;
                        armed_next = 1'b0;
                        pos_next   = POS_IDLE;
                    end
                    else
                    begin
                        ticks_next = ticks_reg - TICK_W'(1);
                    end
                end
            end
            else
            begin
                // Every byte disarms; good transitions re-arm below.
                armed_next = 1'b0;
                unique case (pos_reg) inside
                    POS_IDLE:
                    begin
                        if (b == HDR_FIRST)
                        begin
                            pos_next   = POS_HEADER;
                            armed_next = 1'b1;
                            ticks_next = timeout_reg;
                        end
                    end
                    POS_HEADER:
                    begin
                        if (b == HDR_SECOND)
                        begin
                            pos_next   = POS_D0;
                            armed_next = 1'b1;
                            ticks_next = timeout_reg;
                        end
                        else if (b == HDR_FIRST)
                        begin
                            armed_next = 1'b1;
                            ticks_next = timeout_reg;
                        end
                        else
                        begin
                            pos_next = POS_IDLE;
                        end
                    end
                    POS_D0, POS_D1, POS_D2, POS_D3, POS_D4, POS_D5:
                    begin
                        sum_next   = (pos_reg == POS_D0) ? b : sum_reg + b;
                        data_we    = (pos_reg == POS_D0) || (pos_reg == POS_D1) ||
                                     (pos_reg == POS_D2) || (pos_reg == POS_D3);
                        pos_next   = psfp_pos_t'(pos_reg + 4'd1);
                        armed_next = 1'b1;
                        ticks_next = timeout_reg;
                    end
                    POS_SUM:
                    begin
                        if (b == sum_reg)
                        begin
                            pos_next   = POS_TAIL;
                            armed_next = 1'b1;
                            ticks_next = timeout_reg;
                        end
                        else
                        begin
                            pos_next = POS_IDLE;
                        end
                    end
                    POS_TAIL:
                    begin
                        // A header byte in the tail slot restarts without a timeout.
                        pos_next = (b == HDR_FIRST) ? POS_HEADER : POS_IDLE;
                    end
                    default:
                    begin
                        pos_next = POS_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

### rtl/core/psfp_out_stage.sv
// Result register of the frame parser: holds one result beat until taken.
// Depends on psfp_pkg and psfp_out_if.
module psfp_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  psfp_pkg::psfp_result_t data,
    output logic                   free,
    psfp_out_if.source             res
);
    import psfp_pkg::*;

    logic         valid_reg;
    psfp_result_t data_reg;

    // The register can take a result when empty or when its beat leaves now.
    assign free         = !valid_reg || res.ready;
    assign res.valid    = valid_reg;
    assign res.pm25_raw = data_reg.pm25_raw;
    assign res.pm10_raw = data_reg.pm10_raw;

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

endmodule

### rtl/core/psfp_checker.sv
// Port-level checker for the frame parser, attached by a bind statement.
// Depends on psfp_pkg and the assertion macros in pm_sensor_frame_parser_assert.svh.
module psfp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        evt_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [psfp_pkg::WORD_W-1:0] res_pm25,
    input logic [psfp_pkg::WORD_W-1:0] res_pm10
);
    import psfp_pkg::*;

    `include "pm_sensor_frame_parser_assert.svh"

    // No result may be offered while reset is applied.
    `PSFP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !res_valid, "result valid during reset")

    // With the result register empty, the input side must be open.
    `PSFP_ASSERT(a_ready_when_empty, !res_valid |-> evt_ready, "input stalled with no result pending")

    // A stalled result beat stays offered.
    `PSFP_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped before taken")

    // A stalled result beat keeps its words.
    `PSFP_ASSERT(a_res_stable, res_valid && !res_ready |=> $stable(res_pm25) && $stable(res_pm10), "result changed while stalled")

endmodule

bind pm_sensor_frame_parser psfp_checker u_psfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_ready (evt.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_pm25  (res.pm25_raw),
    .res_pm10  (res.pm10_raw)
);

### dv/testbench.sv
// Self-checking testbench for pm_sensor_frame_parser: directed frames, then random event streams.
// A local frame tracker predicts every result beat. Depends on psfp_pkg, psfp_if and the RTL.
`timescale 1ns / 100ps

module testbench;
    import psfp_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 2000;
    localparam int WATCHDOG_CYCLES = 250000;
    localparam int PHASE_ITEMS     = 400;

    // Ways a generated frame can be broken.
    typedef enum int {
        FLAW_NONE   = 0,
        FLAW_HEADER = 1,
        FLAW_SUM    = 2,
        FLAW_TAIL   = 3,
        FLAW_TRUNC  = 4
    } frame_flaw_t;

    // One row of the directed table; pm25 and pm10 are used only where known is set.
    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] rx_byte;
        logic              known;
        logic [WORD_W-1:0] pm25;
        logic [WORD_W-1:0] pm10;
    } stim_row_t;

    localparam int DIRECTED_N = 24;
    localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_N-1] = '{
        // Tick with no timeout armed, then a stray byte while idle.
        '{OP_TICK, 8'hFF, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000},
        // Header with a repeated first byte, all-zero data and sum.
        '{OP_BYTE, HDR_FIRST, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, HDR_FIRST, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, HDR_SECOND, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'h00, 1'b0, 16'h0000, 16'h0000},
        // A first header byte in place of the tail resynchronizes the parser.
        '{OP_BYTE, HDR_FIRST, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, HDR_SECOND, 1'b0, 16'h0000, 16'h0000},
        // All-ones data, the sum wraps to 0xFA.
        '{OP_BYTE, 8'hFF, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'hFF, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'hFF, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'hFF, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'hFF, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'hFF, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'hFA, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, TAIL_BYTE, 1'b1, 16'hFFFF, 16'hFFFF},
        // Bad second header byte sends the parser idle.
        '{OP_BYTE, HDR_FIRST, 1'b0, 16'h0000, 16'h0000},
        '{OP_BYTE, 8'h12, 1'b0, 16'h0000, 16'h0000}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TICK_W-1:0] cfg_wr_data;

    psfp_in_if  evt_bus ();
    psfp_out_if res_bus ();

    pm_sensor_frame_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .evt         (evt_bus),
        .res         (res_bus)
    );

    // Frame tracker state and the words it expects next.
    psfp_pos_t         trk_pos;
    logic [BYTE_W-1:0] trk_sum;
    logic [BYTE_W-1:0] trk_data [DATA_N];
    logic              trk_armed;
    logic [TICK_W-1:0] trk_left;
    logic [TICK_W-1:0] trk_timeout;
    psfp_result_t      pending_words [$];

    int fail_count   = 0;
    int items_sent   = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Restart the tick countdown from the configured value.
    function automatic void rearm_timeout();
        trk_armed = 1'b1;
        trk_left  = trk_timeout;
    endfunction

    // Apply one event to the tracked frame state; returns 1 when a frame completes.
    function automatic bit track_event(input logic op, input logic [BYTE_W-1:0] b,
                                       output psfp_result_t words);
        int k;
        words = '0;
        if (op == OP_TICK)
        begin
            if (trk_armed)
            begin
                if (trk_left <= 16'd1)
                begin
                    trk_left  = '0;
                    trk_armed = 1'b0;
                    trk_pos   = POS_IDLE;
                end
                else
                begin
                    trk_left = trk_left - 16'd1;
                end
            end
            return 1'b0;
        end
        trk_armed = 1'b0;
        case (trk_pos)
            POS_IDLE:
            begin
                if (b == HDR_FIRST)
                begin
                    trk_pos = POS_HEADER;
                    rearm_timeout();
                end
            end
            POS_HEADER:
            begin
                if (b == HDR_SECOND)
                begin
                    trk_pos = POS_D0;
                    rearm_timeout();
                end
                else if (b == HDR_FIRST)
                begin
                    rearm_timeout();
                end
                else
                begin
                    trk_pos = POS_IDLE;
                end
            end
            POS_D0, POS_D1, POS_D2, POS_D3, POS_D4, POS_D5:
            begin
                k = int'(trk_pos) - int'(POS_D0);
                trk_sum = (k == 0) ? b : trk_sum + b;
                if (k < DATA_N)
                    trk_data[k] = b;
                trk_pos = psfp_pos_t'(trk_pos + 4'd1);
                rearm_timeout();
            end
            POS_SUM:
            begin
                if (b == trk_sum)
                begin
                    trk_pos = POS_TAIL;
                    rearm_timeout();
                end
                else
                begin
                    trk_pos = POS_IDLE;
                end
            end
            POS_TAIL:
            begin
                if (b == TAIL_BYTE)
                begin
                    trk_pos = POS_IDLE;
                    words.pm25_raw = {trk_data[1], trk_data[0]};
                    words.pm10_raw = {trk_data[3], trk_data[2]};
                    return 1'b1;
                end
                trk_pos = (b == HDR_FIRST) ? POS_HEADER : POS_IDLE;
            end
            default:
            begin
                trk_pos = POS_IDLE;
            end
        endcase
        return 1'b0;
    endfunction

    // Offer one event beat with random gaps ahead of it and track it once accepted.
    task automatic push_event(input logic op, input logic [BYTE_W-1:0] b,
                              input bit known, input psfp_result_t known_words);
        psfp_result_t words;
        bit           done;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            evt_bus.valid = 1'b0;
            @(negedge clk);
        end
        evt_bus.valid   = 1'b1;
        evt_bus.op      = op;
        evt_bus.rx_byte = b;
        @(posedge clk);
        while (!evt_bus.ready)
            @(posedge clk);
        done = track_event(op, b, words);
        if (known)
            pending_words.push_back(known_words);
        else if (done)
            pending_words.push_back(words);
        items_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        push_event(OP_BYTE, b, 1'b0, '0);
    endtask

    // Ticks carry a random byte, which the parser must ignore.
    task automatic send_ticks(input int n);
        repeat (n)
            push_event(OP_TICK, BYTE_W'($urandom_range(255)), 1'b0, '0);
    endtask

    // Number of ticks that may fall inside a frame without always expiring it.
    function automatic int tick_cap();
        return (trk_timeout <= 16'd8) ? int'(trk_timeout) : 3;
    endfunction

    // Send one frame with random content, optionally broken in one place.
    task automatic send_frame(input frame_flaw_t flaw);
        logic [BYTE_W-1:0] fb [10];
        logic [BYTE_W-1:0] chk;
        int                cut;
        fb[0] = HDR_FIRST;
        fb[1] = HDR_SECOND;
        chk   = '0;
        for (int i = 0; i < 6; i++)
        begin
            if ($urandom_range(3) == 0)
                fb[2+i] = $urandom_range(1) ? 8'hFF : 8'h00;
            else
                fb[2+i] = BYTE_W'($urandom_range(255));
            chk = chk + fb[2+i];
        end
        fb[8] = chk;
        fb[9] = TAIL_BYTE;
        cut   = 10;
        case (flaw)
            FLAW_HEADER:
            begin
                do
                    fb[1] = BYTE_W'($urandom_range(255));
                while (fb[1] == HDR_SECOND || fb[1] == HDR_FIRST);
            end
            FLAW_SUM:
            begin
                fb[8] = chk ^ BYTE_W'($urandom_range(1, 255));
            end
            FLAW_TAIL:
            begin
                if ($urandom_range(1))
                    fb[9] = HDR_FIRST;
                else
                begin
                    do
                        fb[9] = BYTE_W'($urandom_range(255));
                    while (fb[9] == TAIL_BYTE);
                end
            end
            FLAW_TRUNC:
            begin
                cut = $urandom_range(1, 9);
            end
            default:
            begin
            end
        endcase
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                send_byte(HDR_FIRST);
        for (int i = 0; i < cut; i++)
        begin
            if (i > 0 && $urandom_range(99) < 4)
                send_ticks($urandom_range(1, tick_cap()));
            send_byte(fb[i]);
        end
        // A cut frame is left to the timeout.
        if (flaw == FLAW_TRUNC)
            send_ticks((trk_timeout <= 16'd20) ? int'(trk_timeout) : 4);
    endtask

    // Mostly well-formed frames, the rest broken frames, noise and runs of ticks.
    task automatic run_random(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_frame(FLAW_NONE);
            else if (pick < 70)
                send_frame(frame_flaw_t'($urandom_range(1, 4)));
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(3) == 0) ? HDR_FIRST
                                                       : BYTE_W'($urandom_range(255)));
            end
            else
                send_ticks($urandom_range(1, (trk_timeout <= 16'd20)
                                             ? int'(trk_timeout) + 1 : 5));
        end
    endtask

    // Write the timeout once every expected beat is out and the pipeline is empty.
    task automatic set_timeout(input logic [TICK_W-1:0] value);
        @(negedge clk);
        evt_bus.valid = 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        trk_timeout = value;
    endtask

    // Result receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                res_bus.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                res_bus.ready = ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Compare every accepted result beat with the oldest expected words.
    always @(posedge clk)
    begin : check_results
        psfp_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result beat: pm25_raw %h pm10_raw %h",
                       res_bus.pm25_raw, res_bus.pm10_raw);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (res_bus.pm25_raw !== want.pm25_raw)
                begin
                    $error("pm25_raw mismatch: expected %h, actual %h",
                           want.pm25_raw, res_bus.pm25_raw);
                    fail_count++;
                end
                if (res_bus.pm10_raw !== want.pm10_raw)
                begin
                    $error("pm10_raw mismatch: expected %h, actual %h",
                           want.pm10_raw, res_bus.pm10_raw);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(WATCHDOG_CYCLES * 2 * HALF_PERIOD);
        $display("pm_sensor_frame_parser test failed");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases over several timeouts.
    initial
    begin : main_seq
        int guard;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        evt_bus.valid   = 1'b0;
        evt_bus.op      = OP_BYTE;
        evt_bus.rx_byte = '0;
        res_bus.ready   = 1'b0;
        trk_pos         = POS_IDLE;
        trk_sum         = '0;
        trk_armed       = 1'b0;
        trk_left        = '0;
        trk_timeout     = TIMEOUT_RESET;
        for (int i = 0; i < DATA_N; i++)
            trk_data[i] = '0;
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct = 12;
        snk_idle_pct = 53;
        for (int i = 0; i < DIRECTED_N; i++)
            push_event(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].known,
                       {DIRECTED_ROWS[i].pm25, DIRECTED_ROWS[i].pm10});
        run_random(PHASE_ITEMS);

        set_timeout(16'd1);
        run_random(PHASE_ITEMS);

        // Hold the receiver off while whole frames keep arriving, so the input stalls.
        set_timeout(16'hFFFF);
        hold_req = 1'b1;
        repeat (4)
            send_frame(FLAW_NONE);

        src_idle_pct = 53;
        snk_idle_pct = 12;
        run_random(PHASE_ITEMS);

        set_timeout(16'd3);
        run_random(PHASE_ITEMS);

        set_timeout(TICK_W'($urandom_range(2, 20)));
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(PHASE_ITEMS);

        // Drain the remaining results, then let the pipeline settle.
        @(negedge clk);
        evt_bus.valid = 1'b0;
        guard = 0;
        while (pending_words.size() != 0 && guard < DRAIN_CYCLES)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (pending_words.size() != 0)
        begin
            $error("%0d expected result beats never arrived", pending_words.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("pm_sensor_frame_parser test passed");
        else
            $display("pm_sensor_frame_parser test failed");
        $finish;
    end

endmodule
